/* rtl/core/ldcs_pkg.sv */
// Shared types and constants for the LED driver chain command serializer.
// No dependencies; every other file of the block uses it by scoped names.

package ldcs_pkg;

  // Chain size and command queue depth defaults
  localparam int MAX_DEVICES_DEF = 4;
  localparam int CMD_DEPTH_DEF   = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEVICE_COUNT = 2'd0;
  localparam logic [1:0] REG_BCD_DECODE   = 2'd1;

  // Operation codes
  localparam logic [2:0] OP_DIGIT_WRITE = 3'd0;
  localparam logic [2:0] OP_DIGIT_CLEAR = 3'd1;
  localparam logic [2:0] OP_INTENSITY   = 3'd2;
  localparam logic [2:0] OP_SCAN_LIMIT  = 3'd3;
  localparam logic [2:0] OP_SHUTDOWN    = 3'd4;
  localparam logic [2:0] OP_ACTIVATE    = 3'd5;
  localparam logic [2:0] OP_TEST        = 3'd6;
  localparam logic [2:0] OP_DECODE      = 3'd7;

  // Driver register addresses
  localparam logic [7:0] ADDR_DECODE    = 8'h09;
  localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
  localparam logic [7:0] ADDR_SCAN      = 8'h0B;
  localparam logic [7:0] ADDR_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] ADDR_TEST      = 8'h0F;

  // Data constants
  localparam logic [7:0] DATA_CLEAR_BCD = 8'h0F;
  localparam logic [7:0] DATA_DECODE_ON = 8'hFF;
  localparam logic [7:0] DATA_ON        = 8'h01;
  localparam logic [7:0] DATA_OFF       = 8'h00;

  // One classified command: the word to shift and whether it fills the frame
  typedef struct packed {
    logic [15:0] word;
    logic        bcast;
  } ldcs_cmd_t;

endpackage

/* rtl/core/ldcs_front.sv */
// Front end: accepts operation items and builds the 16-bit command word.
// Depends on ldcs_pkg; feeds ldcs_cmd_fifo.

module ldcs_front (
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_operation,
  input  logic [2:0]           in_position,
  input  logic [7:0]           in_value,
  input  logic                 bcd_decode,
  input  logic                 q_full,
  output logic                 q_push,
  output ldcs_pkg::ldcs_cmd_t  q_cmd
);

  logic [7:0] addr;
  logic [7:0] data;
  logic       bcast;

  // Map the operation to address and data bytes
  always_comb begin
    addr  = ldcs_pkg::ADDR_DECODE;
    data  = ldcs_pkg::DATA_OFF;
    bcast = 1'b1;
    case (in_operation)
      ldcs_pkg::OP_DIGIT_WRITE: begin
        addr  = {5'd0, in_position} + 8'd1;
        data  = in_value;
        bcast = 1'b0;
      end
      ldcs_pkg::OP_DIGIT_CLEAR: begin
        addr  = {5'd0, in_position} + 8'd1;
        data  = bcd_decode ? ldcs_pkg::DATA_CLEAR_BCD : ldcs_pkg::DATA_OFF;
        bcast = 1'b0;
      end
      ldcs_pkg::OP_INTENSITY: begin
        addr = ldcs_pkg::ADDR_INTENSITY;
        data = {4'd0, in_value[3:0]};
      end
      ldcs_pkg::OP_SCAN_LIMIT: begin
        addr = ldcs_pkg::ADDR_SCAN;
        data = (in_value != 8'd0) ? {5'd0, in_value[2:0] - 3'd1} : ldcs_pkg::DATA_OFF;
      end
      ldcs_pkg::OP_SHUTDOWN: begin
        addr = ldcs_pkg::ADDR_SHUTDOWN;
        data = ldcs_pkg::DATA_OFF;
      end
      ldcs_pkg::OP_ACTIVATE: begin
        addr = ldcs_pkg::ADDR_SHUTDOWN;
        data = ldcs_pkg::DATA_ON;
      end
      ldcs_pkg::OP_TEST: begin
        addr = ldcs_pkg::ADDR_TEST;
        data = (in_value != 8'd0) ? ldcs_pkg::DATA_ON : ldcs_pkg::DATA_OFF;
      end
      default: begin
        addr = ldcs_pkg::ADDR_DECODE;
        data = bcd_decode ? ldcs_pkg::DATA_DECODE_ON : ldcs_pkg::DATA_OFF;
      end
    endcase
  end

  // Hand the command to the queue
  assign in_full     = q_full;
  assign q_push      = in_push && !q_full;
  assign q_cmd.word  = {addr, data};
  assign q_cmd.bcast = bcast;

endmodule

/* rtl/core/ldcs_cmd_fifo.sv */
// Short command queue between front end and serializer.
// Depends on ldcs_pkg for the command type.

module ldcs_cmd_fifo #(
  parameter int DEPTH = ldcs_pkg::CMD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  ldcs_pkg::ldcs_cmd_t  wr_cmd,
  output logic                 full,
  input  logic                 rd_en,
  output ldcs_pkg::ldcs_cmd_t  rd_cmd,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ldcs_pkg::ldcs_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* rtl/core/ldcs_back.sv */
// Back end: shifts command words out MSB first, tracks the chain position,
// repeats broadcast words to the end of the frame. Depends on ldcs_pkg.

module ldcs_back #(
  parameter int MAX_DEVICES = ldcs_pkg::MAX_DEVICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           device_count,
  input  logic                 q_empty,
  input  ldcs_pkg::ldcs_cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_data_bit,
  output logic                 out_frame_start,
  output logic                 out_frame_end,
  output logic                 out_last
);

  logic        busy_r;
  logic [15:0] sh_r;
  logic [15:0] word_r;
  logic [3:0]  bit_cnt_r;
  logic        bcast_r;
  logic [2:0]  chain_pos_r, chain_pos_nxt;
  logic        out_vld_r;
  logic        out_data_bit_r, out_frame_start_r, out_frame_end_r, out_last_r;

  logic [2:0]  chain_len;
  logic        adv, bit_last, word_end, item_done, load;

  // Effective chain length: zero acts as one, saturate at the maximum
  always_comb begin
    if (device_count == 3'd0) begin
      chain_len = 3'd1;
    end else if ({1'b0, device_count} > 4'(MAX_DEVICES)) begin
      chain_len = 3'(MAX_DEVICES);
    end else begin
      chain_len = device_count;
    end
  end

  assign adv       = busy_r && (!out_vld_r || out_pop);
  assign bit_last  = (bit_cnt_r == 4'd15);
  assign word_end  = (({1'b0, chain_pos_r} + 4'd1) >= {1'b0, chain_len});
  assign item_done = bit_last && (!bcast_r || word_end);
  assign load      = !q_empty && (!busy_r || (adv && item_done));
  assign q_pop     = load;

  assign chain_pos_nxt = word_end ? 3'd0 : chain_pos_r + 3'd1;

  // Control: busy flag, bit counter, chain position, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      bit_cnt_r   <= 4'd0;
      chain_pos_r <= 3'd0;
      out_vld_r   <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
      if (adv && bit_last) begin
        chain_pos_r <= chain_pos_nxt;
      end
      if (load) begin
        bit_cnt_r <= 4'd0;
      end else if (adv) begin
        bit_cnt_r <= bit_cnt_r + 4'd1;
      end
      if (load) begin
        busy_r <= 1'b1;
      end else if (adv && item_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Payload: shift register, word copy for repeats, output stage
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_bit_r    <= sh_r[15];
      out_frame_start_r <= (bit_cnt_r == 4'd0) && (chain_pos_r == 3'd0);
      out_frame_end_r   <= bit_last && word_end;
      out_last_r        <= item_done;
    end
    if (load) begin
      sh_r    <= q_cmd.word;
      word_r  <= q_cmd.word;
      bcast_r <= q_cmd.bcast;
    end else if (adv) begin
      sh_r <= bit_last ? word_r : {sh_r[14:0], 1'b0};
    end
  end

  assign out_empty       = !out_vld_r;
  assign out_data_bit    = out_data_bit_r;
  assign out_frame_start = out_frame_start_r;
  assign out_frame_end   = out_frame_end_r;
  assign out_last        = out_last_r;

  // Chain position never leaves the range of the largest chain
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, chain_pos_r} < 4'(MAX_DEVICES))
    else $error("chain position out of range");

  // Idle serializer sits at bit zero
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (bit_cnt_r == 4'd0))
    else $error("bit counter moved while idle");

  // A finished broadcast leaves the chain ready
  a_bcast_close: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_done && bcast_r) |=> (chain_pos_r == 3'd0))
    else $error("broadcast left a frame open");

  // The last bit of an item also ends a word
  a_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_done) |-> bit_last)
    else $error("item ended mid-word");

endmodule

/* rtl/core/led_driver_chain_command_serializer_unit.sv */
// Top level of the LED driver chain command serializer.
// Depends on ldcs_pkg, ldcs_front, ldcs_cmd_fifo and ldcs_back.
//
// Usage:
//   Input queue port: an operation item (operation, position, value) is taken
//   when in_push is high and in_full is low. It is classified into a 16-bit
//   command word and parked in a short command queue.
//   Result queue port: one result per serial bit (data_bit, frame_start,
//   frame_end, last); the oldest is shown while out_empty is low and taken
//   with out_pop. out_last marks the final bit of an item.
//   Configuration port: cfg_index/cfg_wdata written when cfg_valid is high;
//   cfg_ready is always high. Index 0 sets the device count, index 1 the
//   decode flag. Write only while the block is idle.
//   Timing: an item passes the command queue, shift register and output
//   register before its first bit shows. The shift register emits one bit
//   per cycle while the receiver pops: 16 bits for a digit write or clear,
//   16 per device left in the frame for a broadcast (64 with four devices).
//   Reset: queue empty, chain ready (position zero), one device, decode off.
//   Receiver stall: the output register holds its bit, the serializer waits,
//   the command queue fills and in_full rises.

module led_driver_chain_command_serializer_unit #(
  parameter int MAX_DEVICES = ldcs_pkg::MAX_DEVICES_DEF,
  parameter int CMD_DEPTH   = ldcs_pkg::CMD_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_operation,
  input  logic [2:0] in_position,
  input  logic [7:0] in_value,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_data_bit,
  output logic       out_frame_start,
  output logic       out_frame_end,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [2:0]          device_count_r;
  logic                bcd_decode_r;
  logic                q_push, q_full, q_pop, q_empty;
  ldcs_pkg::ldcs_cmd_t q_wr_cmd, q_rd_cmd;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_count_r <= 3'd1;
      bcd_decode_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ldcs_pkg::REG_DEVICE_COUNT: device_count_r <= cfg_wdata[2:0];
        ldcs_pkg::REG_BCD_DECODE:   bcd_decode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ldcs_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value     (in_value),
    .bcd_decode   (bcd_decode_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_wr_cmd)
  );

  ldcs_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  ldcs_back #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .device_count    (device_count_r),
    .q_empty         (q_empty),
    .q_cmd           (q_rd_cmd),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data_bit    (out_data_bit),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

endmodule
